/* sv/msrc_pkg.sv */
// Types, constants and the CRC byte update shared by the response checker.
`default_nettype none

package msrc_pkg;

   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  EXPECTED_COUNT    = 8'h08;
   localparam logic [3:0]  FRAME_LEN         = 4'd13;
   localparam logic [3:0]  POS_MAX           = 4'd15;
   localparam logic [3:0]  HEADER_LEN        = 4'd3;
   localparam logic [3:0]  LAST_VALUE_POS    = 4'd10;
   localparam logic [3:0]  CRC_START_POS     = 4'd2;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_SHORT        = 3'd1,
      STATUS_BAD_FUNCTION = 3'd2,
      STATUS_BAD_COUNT    = 3'd3,
      STATUS_TOO_LONG     = 3'd4,
      STATUS_CRC_MISMATCH = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  slave_address;
      logic [15:0] oxygen_mantissa;
      logic [15:0] oxygen_decimals;
      logic [15:0] temperature_mantissa;
      logic [15:0] temperature_decimals;
      logic [15:0] crc_computed;
   } result_type;

   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

/* sv/msrc_channels.sv */
// Request and response channel interfaces of the response checker.
`default_nettype none

interface msrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source(output valid, rx_byte, frame_end, input ready);
   modport sink(input valid, rx_byte, frame_end, output ready);
endinterface

interface msrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  slave_address;
   logic [15:0] oxygen_mantissa;
   logic [15:0] oxygen_decimals;
   logic [15:0] temperature_mantissa;
   logic [15:0] temperature_decimals;
   logic [15:0] crc_computed;

   modport source(output valid, status, slave_address, oxygen_mantissa, oxygen_decimals,
                  temperature_mantissa, temperature_decimals, crc_computed, input ready);
   modport sink(input valid, status, slave_address, oxygen_mantissa, oxygen_decimals,
                temperature_mantissa, temperature_decimals, crc_computed, output ready);
endinterface

`default_nettype wire

/* sv/msrc_frame_state.sv */
// Per-frame state: byte counter, running CRC, captured fields and status evaluation.
`default_nettype none

module msrc_frame_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          data,
   input  wire logic                last,
   output msrc_pkg::result_type     result
);

   logic [3:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  delay0_ff, delay0_in;
   logic [7:0]  delay1_ff, delay1_in;
   logic [7:0]  header_ff [3];
   logic [7:0]  header_in [3];
   logic [15:0] words_ff [4];
   logic [15:0] words_in [4];
   logic [3:0]  value_pos;
   logic [15:0] recv_crc;

   always_comb begin
      crc_in = crc_ff;
      if (pos_ff >= msrc_pkg::CRC_START_POS) begin
         crc_in = msrc_pkg::crc16_feed(crc_ff, delay1_ff);
      end

      header_in = header_ff;
      words_in  = words_ff;
      value_pos = pos_ff - msrc_pkg::HEADER_LEN;
      if (pos_ff < msrc_pkg::HEADER_LEN) begin
         header_in[pos_ff[1:0]] = data;
      end else if (pos_ff <= msrc_pkg::LAST_VALUE_POS) begin
         if (!value_pos[0]) begin
            words_in[value_pos[2:1]] = {data, words_ff[value_pos[2:1]][7:0]};
         end else begin
            words_in[value_pos[2:1]] = {words_ff[value_pos[2:1]][15:8], data};
         end
      end

      recv_crc  = {data, delay0_ff};
      delay1_in = delay0_ff;
      delay0_in = data;
      pos_in    = (pos_ff < msrc_pkg::POS_MAX) ? pos_ff + 4'd1 : msrc_pkg::POS_MAX;

      priority if (pos_in < msrc_pkg::FRAME_LEN) begin
         result.status = msrc_pkg::STATUS_SHORT;
      end else if (header_in[1] != msrc_pkg::FUNC_READ_HOLDING) begin
         result.status = msrc_pkg::STATUS_BAD_FUNCTION;
      end else if (header_in[2] != msrc_pkg::EXPECTED_COUNT) begin
         result.status = msrc_pkg::STATUS_BAD_COUNT;
      end else if (pos_in != msrc_pkg::FRAME_LEN) begin
         result.status = msrc_pkg::STATUS_TOO_LONG;
      end else if (crc_in != recv_crc) begin
         result.status = msrc_pkg::STATUS_CRC_MISMATCH;
      end else begin
         result.status = msrc_pkg::STATUS_OK;
      end

      result.slave_address        = header_in[0];
      result.oxygen_mantissa      = words_in[0];
      result.oxygen_decimals      = words_in[1];
      result.temperature_mantissa = words_in[2];
      result.temperature_decimals = words_in[3];
      result.crc_computed         = crc_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         pos_ff    <= '0;
         crc_ff    <= msrc_pkg::CRC_INIT;
         delay0_ff <= '0;
         delay1_ff <= '0;
         header_ff <= '{default: '0};
         words_ff  <= '{default: '0};
      end else if (step) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         delay0_ff <= delay0_in;
         delay1_ff <= delay1_in;
         header_ff <= header_in;
         words_ff  <= words_in;
      end
   end

endmodule

`default_nettype wire

/* sv/modbus_sensor_response_checker_unit.sv */
// Top level of the Modbus RTU read-holding-registers response checker.
//
// Bytes of one response frame arrive on the req channel, one per transfer, with
// frame_end set on the final byte. Every byte is taken into an input register and
// folded into the frame state when it leaves that register, by a single pass of logic:
// the byte counter, the CRC-16/Modbus byte update and the field capture. Only the
// final byte of a frame yields a transfer on the rsp channel, carrying the status,
// the slave address, the four big-endian words and the computed CRC.
// The result of the final byte is presented on rsp from the result register.
// One byte is accepted in every cycle unless a final byte waits behind a stalled
// result; the rate is set by the byte-wide CRC update in the frame state.
// If the receiver stalls, the result is held in the output register and bytes that
// produce no result keep flowing; only a further final byte waits until the held
// result has been taken. After a frame's result is formed the frame state returns
// to its reset values, ready for the next frame.
// Reset is synchronous and clears the frame state and both registers' valid flags.
`default_nettype none

module modbus_sensor_response_checker_unit (
   input wire logic  clock,
   input wire logic  reset,
   msrc_req_if.sink  req_if,
   msrc_rsp_if.source rsp_if
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   msrc_pkg::result_type out_result_ff;
   msrc_pkg::result_type frame_result;
   logic                 advance;

   assign advance      = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
         in_last_ff <= req_if.frame_end;
      end
   end

   msrc_frame_state frame_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .data   (in_byte_ff),
      .last   (in_last_ff),
      .result (frame_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_result_ff <= frame_result;
      end
   end

   assign rsp_if.valid                = out_valid_ff;
   assign rsp_if.status               = out_result_ff.status;
   assign rsp_if.slave_address        = out_result_ff.slave_address;
   assign rsp_if.oxygen_mantissa      = out_result_ff.oxygen_mantissa;
   assign rsp_if.oxygen_decimals      = out_result_ff.oxygen_decimals;
   assign rsp_if.temperature_mantissa = out_result_ff.temperature_mantissa;
   assign rsp_if.temperature_decimals = out_result_ff.temperature_decimals;
   assign rsp_if.crc_computed         = out_result_ff.crc_computed;

   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> out_valid_ff)
      else $error("Final byte did not produce a result.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && out_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("Input taken while a final byte waits behind a stalled result.");

   assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("Valid flags not cleared by reset.");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_if.ready && !(advance && in_last_ff)) |=> !out_valid_ff)
      else $error("Result transfer repeated.");

endmodule

`default_nettype wire
